// ----- design/ats_pkg.sv -----
package ats_pkg;
  localparam int MaxEntries = 1024;
  localparam int IdxW = 10;
  localparam int CntW = 11;
  localparam int WeightW = 32;
  localparam int RandW = 32;
  localparam int SumW = 42;
  localparam int ResW = 43;
  localparam logic [1:0] ST_BUILT = 2'd0;
  localparam logic [1:0] ST_SAMPLE = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
endpackage

// ----- design/alias_table_sampler_core.sv -----
// load word: handled in the idle state; an error result is valid the cycle after its word
// build after the last weight: a residual pass, a classify pass, small/large pairing
//   and then the leftover entries
// sample: result after S_SMP_MUL, S_SMP_RD and S_SMP_CMP, two registered table reads and split products
// the result register holds off the input until the result word is taken
// rst_n synchronous active low clears sums, counts and flags; memories are not cleared
module alias_table_sampler_core import ats_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // weight[31:0], rand_column[63:32], rand_accept[95:64]
  input  logic        in_tlast,   // last
  input  logic        in_tuser,   // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // index[9:0], entry_count[20:10], zero pad
  output logic [1:0]  out_tuser   // status[1:0]
);
  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_CLS_RD, S_CLS, S_POP_RD, S_POP_S, S_POP_L, S_POP_UPD,
    S_FIN_RD, S_FIN, S_SMP_MUL, S_SMP_RD, S_SMP_CMP, S_OUT
  } state_t;

  // memories
  logic [WeightW-1:0] weight_mem [MaxEntries];
  logic [ResW-1:0]    res_mem    [MaxEntries];
  logic [SumW-1:0]    prob_mem   [MaxEntries];
  logic [IdxW-1:0]    alias_mem  [MaxEntries];
  logic [IdxW-1:0]    small_mem  [MaxEntries];
  logic [IdxW-1:0]    large_mem  [MaxEntries];

  state_t          state_r;
  logic [SumW-1:0] sum_r;
  logic [CntW-1:0] cnt_r, k_r, ns_r, nl_r;
  logic            ready_r, ovf_r, fin_small_r;
  logic [IdxW-1:0] s_r, l_r;
  logic [ResW-1:0] wrd_r, rs_r;
  logic [WeightW-1:0] wd_r;
  logic [SumW-1:0] prd_r;
  logic [IdxW-1:0] ard_r, srd_r, lrd_r, col_r;
  logic [RandW-1:0] u1_r, u2_r;
  logic [2*RandW-1:0] plo_r;
  logic [RandW+SumW-33:0] phi_r;
  logic [1:0]      ost_r;
  logic [IdxW-1:0] oidx_r;
  logic [CntW-1:0] ocnt_r;
  logic            ovalid_r;

  logic [WeightW-1:0] w_in;
  logic [CntW+RandW-1:0] colp;
  logic [IdxW-1:0]    colc;
  logic [ResW-1:0]    res_new;
  logic [RandW+SumW-1:0] prod;

  assign w_in = in_tdata[31:0];
  assign colp = cnt_r * u1_r;
  assign colc = (colp[CntW+RandW-1:RandW] >= cnt_r) ? IdxW'(cnt_r - 1'b1)
              : colp[RandW+IdxW-1:RandW];
  assign res_new = wrd_r - ({1'b0, sum_r} - rs_r);
  // u2 * sum from two partial products
  assign prod = {{(SumW-32){1'b0}}, plo_r} + {phi_r, 32'd0};

  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tdata = {3'b000, ocnt_r, oidx_r};
  assign out_tuser = ost_r;

  // weight memory and table reads
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready && !in_tuser &&
        (ready_r ? 1'b1 : (!ovf_r && cnt_r < CntW'(MaxEntries))))
      weight_mem[ready_r ? '0 : cnt_r[IdxW-1:0]] <= w_in;
    wd_r  <= weight_mem[k_r[IdxW-1:0]];
    rs_r  <= res_mem[state_r == S_POP_S ? srd_r : (state_r == S_POP_L ? lrd_r : k_r[IdxW-1:0])];
    prd_r <= prob_mem[colc];
    ard_r <= alias_mem[colc];
    srd_r <= small_mem[IdxW'(ns_r - 1'b1)];
    lrd_r <= large_mem[IdxW'(nl_r - 1'b1)];
    plo_r <= u2_r * sum_r[31:0];
    phi_r <= u2_r * sum_r[SumW-1:32];
  end

  // control and table writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; sum_r <= '0; cnt_r <= '0; ready_r <= 1'b0; ovf_r <= 1'b0;
      ovalid_r <= 1'b0; k_r <= '0; ns_r <= '0; nl_r <= '0;
    end else begin
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          u1_r <= in_tdata[63:32]; u2_r <= in_tdata[95:64];
          if (in_tuser) begin
            if (!ready_r || cnt_r == '0) begin
              ost_r <= ST_ERROR; oidx_r <= '0; ocnt_r <= cnt_r; ovalid_r <= 1'b1;
            end else state_r <= S_SMP_MUL;
          end else begin
            logic [CntW-1:0] c; logic [SumW-1:0] sm; logic ov;
            c = ready_r ? '0 : cnt_r; sm = ready_r ? '0 : sum_r; ov = ready_r ? 1'b0 : ovf_r;
            ready_r <= 1'b0;
            if (c >= CntW'(MaxEntries)) ov = 1'b1;
            else begin c = c + 1'b1; sm = sm + SumW'(w_in); end
            if (in_tlast) begin
              if (ov || sm == '0) begin
                ost_r <= ST_ERROR; oidx_r <= '0; ocnt_r <= c; ovalid_r <= 1'b1;
                c = '0; sm = '0; ov = 1'b0;
              end else begin
                k_r <= '0; state_r <= S_MUL;
              end
            end
            cnt_r <= c; sum_r <= sm; ovf_r <= ov;
          end
        end
        // residual = weight * count, one entry per S_MUL/S_CLS_RD pass
        S_MUL: state_r <= S_CLS_RD;
        S_CLS_RD: begin
          res_mem[k_r[IdxW-1:0]] <= {{(ResW-WeightW){1'b0}}, wd_r} *
                                    {{(ResW-CntW){1'b0}}, cnt_r};
          if (k_r + 1'b1 == cnt_r) begin
            k_r <= cnt_r; ns_r <= '0; nl_r <= '0; state_r <= S_CLS;
          end else begin k_r <= k_r + 1'b1; state_r <= S_MUL; end
        end
        // classify from the top index down
        S_CLS: begin
          if (k_r == '0) state_r <= S_POP_RD;
          else begin k_r <= k_r - 1'b1; state_r <= S_FIN; fin_small_r <= 1'b0; end
        end
        S_FIN: begin
          if (!fin_small_r) begin fin_small_r <= 1'b1; end
          else begin
            if (rs_r < {1'b0, sum_r}) begin
              small_mem[ns_r[IdxW-1:0]] <= k_r[IdxW-1:0]; ns_r <= ns_r + 1'b1;
            end else begin
              large_mem[nl_r[IdxW-1:0]] <= k_r[IdxW-1:0]; nl_r <= nl_r + 1'b1;
            end
            state_r <= S_CLS;
          end
        end
        // pair small and large
        S_POP_RD: begin
          if (ns_r != '0 && nl_r != '0) state_r <= S_POP_S;
          else if (ns_r != '0 || nl_r != '0) state_r <= S_FIN_RD;
          else begin
            ready_r <= 1'b1; ost_r <= ST_BUILT; oidx_r <= '0; ocnt_r <= cnt_r;
            ovalid_r <= 1'b1; state_r <= S_IDLE;
          end
        end
        S_POP_S: begin s_r <= srd_r; l_r <= lrd_r; state_r <= S_POP_L; end
        S_POP_L: begin
          prob_mem[s_r] <= rs_r[SumW-1:0]; alias_mem[s_r] <= l_r;
          wrd_r <= rs_r; state_r <= S_POP_UPD;
        end
        S_POP_UPD: begin
          res_mem[l_r] <= res_new;
          if (res_new < {1'b0, sum_r}) begin
            small_mem[IdxW'(ns_r - 1'b1)] <= l_r; nl_r <= nl_r - 1'b1;
          end else begin
            large_mem[IdxW'(nl_r - 1'b1)] <= l_r; ns_r <= ns_r - 1'b1;
          end
          state_r <= S_POP_RD;
        end
        // leftovers get full probability
        S_FIN_RD: begin
          logic [IdxW-1:0] e;
          e = (nl_r != '0) ? lrd_r : srd_r;
          prob_mem[e] <= sum_r; alias_mem[e] <= e;
          if (nl_r != '0) nl_r <= nl_r - 1'b1; else ns_r <= ns_r - 1'b1;
          state_r <= S_POP_RD;
        end
        // sampling
        S_SMP_MUL: begin col_r <= colc; state_r <= S_SMP_RD; end
        S_SMP_RD: state_r <= S_SMP_CMP;
        S_SMP_CMP: begin
          ost_r <= ST_SAMPLE; ocnt_r <= cnt_r;
          oidx_r <= (prod < {prd_r, 32'd0}) ? col_r : ard_r;
          ovalid_r <= 1'b1; state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- bench/tb_alias_table_sampler_core.sv -----
`timescale 1ns / 100ps

module tb_alias_table_sampler_core;
  import ats_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // weight[31:0], rand_column[63:32], rand_accept[95:64]
  logic        in_tlast = 1'b0; // last
  logic        in_tuser = 1'b0; // op
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // index[9:0], entry_count[20:10]
  logic [1:0]  out_tuser;       // status

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  typedef struct packed {
    logic [1:0]      status;
    logic [IdxW-1:0] index;
    logic [CntW-1:0] entry_count;
  } result_t;

  typedef struct {
    logic        op;
    logic [31:0] weight;
    logic        last;
    logic [31:0] u_col;
    logic [31:0] u_acc;
    bit          typed;
    result_t     res;
  } row_t;

  alias_table_sampler_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  // predictor state
  longint unsigned wt_mem [MaxEntries];
  longint unsigned res_mem [MaxEntries];
  longint unsigned prob_mem [MaxEntries];
  int unsigned     alias_mem [MaxEntries];
  int unsigned     stk_small [MaxEntries];
  int unsigned     stk_large [MaxEntries];
  longint unsigned sum_w;
  int unsigned     n_loaded;
  bit              ready_tbl;
  bit              ovf;

  result_t pending_results [$];
  int      errors = 0;
  bit      idle_en = 1'b1;
  bit      long_hold = 1'b0;

  localparam longint unsigned SumCap = 64'hFFFF_FFFF_FFFF_FFFF / MaxEntries;

  function automatic void clear_list();
    sum_w = 0;
    n_loaded = 0;
    ovf = 1'b0;
  endfunction

  // vose pairing over the loaded weights
  function automatic void build_alias();
    int unsigned ns, nl, s, l, e;
    ns = 0;
    nl = 0;
    for (int k = 0; k < n_loaded; k++) res_mem[k] = wt_mem[k] * n_loaded;
    for (int k = n_loaded; k > 0; k--) begin
      e = k - 1;
      if (res_mem[e] < sum_w) stk_small[ns++] = e;
      else stk_large[nl++] = e;
    end
    while (ns > 0 && nl > 0) begin
      s = stk_small[--ns];
      l = stk_large[--nl];
      prob_mem[s] = res_mem[s];
      alias_mem[s] = l;
      res_mem[l] -= sum_w - res_mem[s];
      if (res_mem[l] < sum_w) stk_small[ns++] = l;
      else stk_large[nl++] = l;
    end
    while (nl > 0) begin
      e = stk_large[--nl];
      prob_mem[e] = sum_w;
      alias_mem[e] = e;
    end
    while (ns > 0) begin
      e = stk_small[--ns];
      prob_mem[e] = sum_w;
      alias_mem[e] = e;
    end
  endfunction

  function automatic bit predict_word(input logic op, input logic [31:0] w, input logic lst,
                                      input logic [31:0] u1, input logic [31:0] u2,
                                      output result_t r);
    longint unsigned col;
    logic [127:0] lhs, rhs;
    r = '0;
    if (op == OP_LOAD) begin
      if (ready_tbl) begin
        ready_tbl = 1'b0;
        clear_list();
      end
      if (n_loaded >= MaxEntries || {32'b0, w} > SumCap - sum_w) ovf = 1'b1;
      else begin
        wt_mem[n_loaded] = {32'b0, w};
        n_loaded++;
        sum_w += {32'b0, w};
      end
      if (!lst) return 1'b0;
      r.entry_count = CntW'(n_loaded);
      if (ovf || sum_w == 0) begin
        r.status = ST_ERROR;
        clear_list();
        return 1'b1;
      end
      build_alias();
      ready_tbl = 1'b1;
      r.status = ST_BUILT;
      return 1'b1;
    end
    r.entry_count = CntW'(n_loaded);
    if (!ready_tbl || n_loaded == 0) begin
      r.status = ST_ERROR;
      return 1'b1;
    end
    col = ({32'b0, n_loaded} * {32'b0, u1}) >> RandW;
    if (col >= n_loaded) col = n_loaded - 1;
    lhs = {96'b0, u2} * {64'b0, sum_w};
    rhs = {64'b0, prob_mem[col]} << RandW;
    r.status = ST_SAMPLE;
    r.index = (lhs < rhs) ? IdxW'(col) : IdxW'(alias_mem[col]);
    return 1'b1;
  endfunction

  // drive one word and wait for its handshake
  task automatic send_word(input logic op, input logic [31:0] w, input logic lst,
                           input logic [31:0] u1, input logic [31:0] u2,
                           input bit typed = 1'b0, input result_t tres = '0);
    result_t r;
    bit acc;
    int gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tlast <= lst;
    in_tdata <= {u2, u1, w};
    do begin
      @(negedge clk);
      acc = in_tready;
      @(posedge clk);
    end while (!acc);
    if (predict_word(op, w, lst, u1, u2, r)) begin
      if (typed && r != tres)
        $display("note: typed row differs from predictor");
      pending_results.push_back(typed ? tres : r);
    end
  endtask

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      default: return $urandom;
    endcase
  endfunction

  // receiver ready with random stall bursts and one long hold
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
        out_tready <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (hold - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker
  initial begin
    bit take;
    result_t got, want;
    forever begin
      @(negedge clk);
      take = out_tvalid && out_tready && rst_n;
      got = '{out_tuser, out_tdata[9:0], out_tdata[20:10]};
      @(posedge clk);
      if (take) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result word status=%0d index=%0d", got.status, got.index);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.status != want.status) begin
            $error("status expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          if (got.index != want.index) begin
            $error("index expected %0d actual %0d", want.index, got.index);
            errors++;
          end
          if (got.entry_count != want.entry_count) begin
            $error("entry_count expected %0d actual %0d", want.entry_count, got.entry_count);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    row_t rows [$];
    int items, n, k;
    ready_tbl = 1'b0;
    clear_list();
    rows = '{
      // draw before any build
      '{OP_DRAW, 32'd0, 1'b0, 32'd0, 32'd0, 1'b1, '{ST_ERROR, 10'd0, 11'd0}},
      // zero sum build
      '{OP_LOAD, 32'd0, 1'b1, 32'd0, 32'd0, 1'b1, '{ST_ERROR, 10'd0, 11'd1}},
      // extreme weights
      '{OP_LOAD, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0, 1'b0, '0},
      '{OP_LOAD, 32'd1, 1'b1, 32'd0, 32'd0, 1'b1, '{ST_BUILT, 10'd0, 11'd2}},
      '{OP_DRAW, 32'd0, 1'b0, 32'd0, 32'd0, 1'b0, '0},
      '{OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'd0, 1'b0, '0},
      '{OP_DRAW, 32'd0, 1'b0, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
      // single entry table always answers entry 0
      '{OP_LOAD, 32'd5, 1'b1, 32'd0, 32'd0, 1'b1, '{ST_BUILT, 10'd0, 11'd1}},
      '{OP_DRAW, 32'd0, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{ST_SAMPLE, 10'd0, 11'd1}},
      // three entries, load over a ready table
      '{OP_LOAD, 32'd1, 1'b0, 32'd0, 32'd0, 1'b0, '0},
      '{OP_LOAD, 32'd2, 1'b0, 32'd0, 32'd0, 1'b0, '0},
      '{OP_LOAD, 32'd3, 1'b1, 32'd0, 32'd0, 1'b1, '{ST_BUILT, 10'd0, 11'd3}},
      '{OP_DRAW, 32'd0, 1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
      '{OP_DRAW, 32'd0, 1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
      '{OP_DRAW, 32'd0, 1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0}
    };
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_word(rows[i].op, rows[i].weight, rows[i].last, rows[i].u_col, rows[i].u_acc,
                rows[i].typed, rows[i].res);

    items = rows.size();
    while (items < 950) begin
      if (items > 850) idle_en = 1'b0;
      if (items > 300 && items < 320) long_hold = 1'b1;
      if (items > 600 && items < 620) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) < 8) begin
        // well-formed list then draws
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) send_word(OP_LOAD, rand_weight(), k == n - 1, $urandom, $urandom);
        items += n;
        n = $urandom_range(1, 10);
        repeat (n) send_word(OP_DRAW, $urandom, 1'($urandom_range(0, 1)), $urandom, $urandom);
        items += n;
      end else if ($urandom_range(0, 1) == 0) begin
        // zero sum list
        n = $urandom_range(1, 3);
        for (k = 0; k < n; k++) send_word(OP_LOAD, '0, k == n - 1, $urandom, $urandom);
        items += n;
      end else begin
        send_word(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)),
                  $urandom, $urandom);
        items++;
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/ats_pkg.sv
design/alias_table_sampler_core.sv
bench/tb_alias_table_sampler_core.sv
